/* sv/rbad_pkg.sv */
// Shared constants, register codes and helpers for the RGB block-average downscaler.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package rbad_pkg;

    // Bounds of the frame and tile geometry
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_BLOCK  = 16;

    // Pixel and channel layout
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int PIX_W     = NUM_CH * CH_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int DIM_REG_W  = 9;
    localparam int BS_REG_W   = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_BLOCK_SIZE   = 2'd2
    } t_cfg_idx;

    // Register reset values
    localparam int RST_FRAME_WIDTH  = 160;
    localparam int RST_FRAME_HEIGHT = 144;
    localparam int RST_BLOCK_SIZE   = 2;

    // Zero maps to one, anything above the limit saturates
    function automatic logic [31:0] clamp_reg(logic [31:0] v, logic [31:0] hi);
        logic [31:0] r;
        if (v == 32'd0) begin
            r = 32'd1;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/rbad_pix_if.sv */
// Pixel input channel: valid/ready handshake carrying one packed RGB word.
// Depends on rbad_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rbad_pix_if;
    import rbad_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_color;

    modport source (output valid, output pixel_color, input ready);
    modport sink   (input valid, input pixel_color, output ready);
endinterface

`default_nettype wire

/* sv/rbad_avg_if.sv */
// Result channel: valid/ready handshake carrying one tile average and its flags.
// Depends on rbad_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rbad_avg_if;
    import rbad_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] avg_red;
    logic [CH_W-1:0] avg_green;
    logic [CH_W-1:0] avg_blue;
    logic            row_done;
    logic            frame_done;

    modport source (output valid, output avg_red, output avg_green, output avg_blue,
                    output row_done, output frame_done, input ready);
    modport sink   (input valid, input avg_red, input avg_green, input avg_blue,
                    input row_done, input frame_done, output ready);
endinterface

`default_nettype wire

/* sv/rbad_band_mem.sv */
// Line store of per-tile-column channel sums: one write port, one registered read port.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module rbad_band_mem #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 48
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0]        i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* sv/rbad_divider.sv */
// Three-lane restoring divider, one quotient bit per cycle, for the tile averages.
// Quotients are known to fit CH_W bits. Depends on rbad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbad_divider #(
    parameter int SUM_W = 16,
    parameter int CNT_W = 10
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic [rbad_pkg::NUM_CH-1:0][SUM_W-1:0] i_num,
    input  wire logic [CNT_W-1:0]                      i_den,
    output logic                                       o_done,
    output logic [rbad_pkg::NUM_CH-1:0][rbad_pkg::CH_W-1:0] o_quot
);
    import rbad_pkg::*;

    localparam int DV_W   = ((SUM_W > CNT_W - 1) ? SUM_W : CNT_W - 1) + CH_W;
    localparam int STEP_W = (CH_W > 1) ? $clog2(CH_W) : 1;

    logic [NUM_CH-1:0][SUM_W-1:0] r_rem, n_rem;
    logic [NUM_CH-1:0][CH_W-1:0]  n_quot;
    logic [DV_W-1:0]              r_dvs;
    logic [STEP_W-1:0]            r_step;
    logic                         r_busy;

    // Trial subtract of the shifted divisor in every lane
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            if (DV_W'(r_rem[k]) >= r_dvs) begin
                n_rem[k]  = SUM_W'(DV_W'(r_rem[k]) - r_dvs);
                n_quot[k] = {o_quot[k][CH_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = r_rem[k];
                n_quot[k] = {o_quot[k][CH_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else if (i_start) begin
            r_rem  <= i_num;
            r_dvs  <= DV_W'(i_den) << (CH_W - 1);
            o_quot <= '0;
            r_step <= STEP_W'(CH_W - 1);
            r_busy <= 1'b1;
            o_done <= 1'b0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            o_quot <= n_quot;
            r_dvs  <= r_dvs >> 1;
            if (r_step == '0) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end else begin
                r_step <= r_step - STEP_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* sv/rgb_block_average_downscale.sv */
// Box-filter downscaler: averages each block_size x block_size tile of an RGB raster frame.
// Pixel that closes no tile: line-store read, then sum write-back in S_READ.
// Pixel that closes a tile: line-store read, add, divider steps (one quotient bit per cycle),
// output load; the result is held in the divider while the output is stalled.
// Reset: registers to 160 x 144, tile 2; position cleared; line store not cleared, since
// each tile entry is overwritten by its first pixel before its contents are used.
`timescale 1ns / 1ps
`default_nettype none

module rgb_block_average_downscale #(
    parameter int MAX_WIDTH  = rbad_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rbad_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_BLOCK  = rbad_pkg::DEF_MAX_BLOCK
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [rbad_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rbad_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rbad_pix_if.sink                           i_pix,
    rbad_avg_if.source                         o_avg
);
    import rbad_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int BSW   = $clog2(MAX_BLOCK + 1);
    localparam int BW    = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int SUM_W = $clog2(MAX_BLOCK * MAX_BLOCK * 255 + 1);
    localparam int CNT_W = 2 * BSW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV
    } t_state;

    t_state r_state;

    // Configuration, stored already clamped
    logic [WW-1:0]  r_w;
    logic [HW-1:0]  r_h;
    logic [BSW-1:0] r_bs;

    // Frame position
    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [BW-1:0] r_cit;
    logic [BW-1:0] r_rit;
    logic [XW-1:0] r_tile;

    // Item in flight
    logic [PIX_W-1:0] r_pix;
    logic [XW-1:0]    r_wtile;
    logic             r_first;
    logic             r_emit;
    logic             r_rd;
    logic             r_fd;
    logic [CNT_W-1:0] r_cnt;

    // Output register
    logic            r_out_valid;
    logic [CH_W-1:0] r_out_red;
    logic [CH_W-1:0] r_out_green;
    logic [CH_W-1:0] r_out_blue;
    logic            r_out_rd;
    logic            r_out_fd;

    logic                        accept;
    logic                        last_x;
    logic                        last_y;
    logic [BSW-1:0]              cit_p1;
    logic [BSW-1:0]              rit_p1;
    logic                        tile_end;
    logic                        band_end;
    logic                        out_free;
    logic [NUM_CH*SUM_W-1:0]     rd_data;
    logic [NUM_CH-1:0][SUM_W-1:0] sums;
    logic                        div_start;
    logic                        div_done;
    logic [NUM_CH-1:0][CH_W-1:0] quot;

    assign i_pix.ready = (r_state == S_IDLE);
    assign accept      = i_pix.valid && i_pix.ready;

    assign last_x   = (WW'(r_x) + WW'(1)) == r_w;
    assign last_y   = (HW'(r_y) + HW'(1)) == r_h;
    assign cit_p1   = BSW'(r_cit) + BSW'(1);
    assign rit_p1   = BSW'(r_rit) + BSW'(1);
    assign tile_end = (cit_p1 == r_bs);
    assign band_end = (rit_p1 == r_bs);

    assign out_free  = !r_out_valid || o_avg.ready;
    assign div_start = (r_state == S_READ) && r_emit;

    // Channel k: 0 blue, 1 green, 2 red
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            if (r_first) begin
                sums[k] = SUM_W'(r_pix[k*CH_W +: CH_W]);
            end else begin
                sums[k] = rd_data[k*SUM_W +: SUM_W] + SUM_W'(r_pix[k*CH_W +: CH_W]);
            end
        end
    end

    rbad_band_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (NUM_CH * SUM_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_READ),
        .i_wr_addr (r_wtile),
        .i_wr_data (sums),
        .i_rd_en   (accept),
        .i_rd_addr (r_tile),
        .o_rd_data (rd_data)
    );

    rbad_divider #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (sums),
        .i_den   (r_cnt),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_w         <= WW'(clamp_reg(32'(RST_FRAME_WIDTH), 32'(MAX_WIDTH)));
            r_h         <= HW'(clamp_reg(32'(RST_FRAME_HEIGHT), 32'(MAX_HEIGHT)));
            r_bs        <= BSW'(clamp_reg(32'(RST_BLOCK_SIZE), 32'(MAX_BLOCK)));
            r_x         <= '0;
            r_y         <= '0;
            r_cit       <= '0;
            r_rit       <= '0;
            r_tile      <= '0;
        end else begin
            if (o_avg.valid && o_avg.ready) begin
                r_out_valid <= 1'b0;
            end

            // A write to any of the three registers restarts the frame
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_WIDTH: begin
                        r_w <= WW'(clamp_reg(32'(i_cfg_data[DIM_REG_W-1:0]),
                                             32'(MAX_WIDTH)));
                    end
                    CFG_FRAME_HEIGHT: begin
                        r_h <= HW'(clamp_reg(32'(i_cfg_data[DIM_REG_W-1:0]),
                                             32'(MAX_HEIGHT)));
                    end
                    CFG_BLOCK_SIZE: begin
                        r_bs <= BSW'(clamp_reg(32'(i_cfg_data[BS_REG_W-1:0]),
                                               32'(MAX_BLOCK)));
                    end
                    default: begin
                    end
                endcase
                if (i_cfg_idx == CFG_FRAME_WIDTH || i_cfg_idx == CFG_FRAME_HEIGHT ||
                    i_cfg_idx == CFG_BLOCK_SIZE) begin
                    r_x    <= '0;
                    r_y    <= '0;
                    r_cit  <= '0;
                    r_rit  <= '0;
                    r_tile <= '0;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_pix   <= i_pix.pixel_color;
                        r_wtile <= r_tile;
                        r_first <= (r_cit == '0) && (r_rit == '0);
                        r_emit  <= (tile_end || last_x) && (band_end || last_y);
                        r_rd    <= last_x;
                        r_fd    <= last_x && last_y;
                        // Pixels present in the tile when its last pixel arrives
                        r_cnt   <= CNT_W'(cit_p1) * CNT_W'(rit_p1);
                        if (last_x) begin
                            r_x    <= '0;
                            r_cit  <= '0;
                            r_tile <= '0;
                            if (last_y) begin
                                r_y   <= '0;
                                r_rit <= '0;
                            end else begin
                                r_y   <= r_y + YW'(1);
                                r_rit <= band_end ? '0 : rit_p1[BW-1:0];
                            end
                        end else begin
                            r_x <= r_x + XW'(1);
                            if (tile_end) begin
                                r_cit  <= '0;
                                r_tile <= r_tile + XW'(1);
                            end else begin
                                r_cit <= cit_p1[BW-1:0];
                            end
                        end
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= r_emit ? S_DIV : S_IDLE;
                end
                S_DIV: begin
                    if (div_done && out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_blue  <= quot[0];
                        r_out_green <= quot[1];
                        r_out_red   <= quot[2];
                        r_out_rd    <= r_rd;
                        r_out_fd    <= r_fd;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_avg.valid      = r_out_valid;
    assign o_avg.avg_red    = r_out_red;
    assign o_avg.avg_green  = r_out_green;
    assign o_avg.avg_blue   = r_out_blue;
    assign o_avg.row_done   = r_out_rd;
    assign o_avg.frame_done = r_out_fd;

endmodule

`default_nettype wire

/* tb/sv/rgb_block_average_downscale_tb.sv */
// Self-checking testbench for rgb_block_average_downscale: directed rows, then random frames.
// A tile-average predictor is checked result by result; depends on rbad_pkg and both interfaces.
`timescale 1ns / 1ps

module rgb_block_average_downscale_tb;
    import rbad_pkg::*;

    localparam int MAX_W          = DEF_MAX_WIDTH;
    localparam int MAX_H          = DEF_MAX_HEIGHT;
    localparam int MAX_BS         = DEF_MAX_BLOCK;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;  // no register behind it
    localparam int SETTLE_CYC     = 24;
    localparam int HOLD_CYC       = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RAND_ITEMS     = 1750;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            row_done;
        logic            frame_done;
    } t_tile_avg;

    typedef enum logic [1:0] {ROW_PIX, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        logic [CFG_IDX_W-1:0]     idx;
        logic [CFG_DATA_W-1:0]    data;
        logic [PIX_W-1:0]         pix;
        logic                     typed;
        t_tile_avg                want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    rbad_pix_if pix_if ();
    rbad_avg_if avg_if ();

    rgb_block_average_downscale dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_avg      (avg_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state
    logic [DIM_REG_W-1:0] wid_cfg;
    logic [DIM_REG_W-1:0] hgt_cfg;
    logic [BS_REG_W-1:0]  bs_cfg;
    logic [15:0]          band_sum [0:MAX_W-1][0:NUM_CH-1];
    logic [7:0]           col_pos;
    logic [7:0]           row_pos;
    logic [3:0]           col_in_tile;
    logic [3:0]           row_in_tile;

    t_tile_avg tile_q [$];
    int        err_cnt    = 0;
    bit        hold_req   = 1'b0;
    int        idle_cnt   = 0;

    function automatic int fit_range(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void restart_pos();
        col_pos     = '0;
        row_pos     = '0;
        col_in_tile = '0;
        row_in_tile = '0;
    endfunction

    function automatic void box_cfg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_FRAME_WIDTH: begin
                wid_cfg = data[DIM_REG_W-1:0];
                restart_pos();
            end
            CFG_FRAME_HEIGHT: begin
                hgt_cfg = data[DIM_REG_W-1:0];
                restart_pos();
            end
            CFG_BLOCK_SIZE: begin
                bs_cfg = data[BS_REG_W-1:0];
                restart_pos();
            end
            default: ;
        endcase
    endfunction

    function automatic void box_avg_step(input logic [PIX_W-1:0] pix, output bit hit,
                                         output t_tile_avg res);
        int         w, h, bs, x, y, tile, x0, y0, cw, chh, cnt, nc, nr, ncit, nrit;
        logic [7:0] chan [0:NUM_CH-1];
        logic [7:0] mean [0:NUM_CH-1];
        bit         lc, lr;
        w = fit_range(int'(wid_cfg), MAX_W);
        h = fit_range(int'(hgt_cfg), MAX_H);
        bs = fit_range(int'(bs_cfg), MAX_BS);
        x = col_pos;
        y = row_pos;
        if (x >= w || y >= h || col_in_tile >= bs || row_in_tile >= bs) begin
            restart_pos();
            x = 0;
            y = 0;
        end
        tile = (x / bs) % MAX_W;
        chan[0] = pix[23:16];
        chan[1] = pix[15:8];
        chan[2] = pix[7:0];
        for (int k = 0; k < NUM_CH; k++) begin
            if (col_in_tile == 0 && row_in_tile == 0) begin
                band_sum[tile][k] = 16'(chan[k]);
            end else begin
                band_sum[tile][k] = band_sum[tile][k] + 16'(chan[k]);
            end
        end
        lc = (col_in_tile == bs - 1) || (x == w - 1);
        lr = (row_in_tile == bs - 1) || (y == h - 1);
        hit = lc && lr;
        res = '0;
        if (hit) begin
            x0 = x - col_in_tile;
            y0 = y - row_in_tile;
            cw = (w - x0 < bs) ? (w - x0) : bs;
            chh = (h - y0 < bs) ? (h - y0) : bs;
            cnt = cw * chh;
            if (cnt == 0) cnt = 1;
            for (int k = 0; k < NUM_CH; k++) begin
                mean[k] = 8'(int'(band_sum[tile][k]) / cnt);
            end
            res.red = mean[0];
            res.green = mean[1];
            res.blue = mean[2];
            res.row_done = (x == w - 1);
            res.frame_done = (x == w - 1) && (y == h - 1);
        end
        // advance the raster position
        nc = x + 1;
        ncit = col_in_tile + 1;
        nrit = row_in_tile;
        nr = y;
        if (ncit >= bs) ncit = 0;
        if (nc >= w) begin
            nc = 0;
            ncit = 0;
            nr = y + 1;
            nrit = row_in_tile + 1;
            if (nrit >= bs) nrit = 0;
            if (nr >= h) begin
                nr = 0;
                nrit = 0;
            end
        end
        col_pos = 8'(nc);
        row_pos = 8'(nr);
        col_in_tile = 4'(ncit);
        row_in_tile = 4'(nrit);
    endfunction

    function automatic t_dir_row mk_cfg(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        t_dir_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic t_dir_row mk_pix(input logic [PIX_W-1:0] pix);
        t_dir_row r;
        r = '0;
        r.kind = ROW_PIX;
        r.pix = pix;
        return r;
    endfunction

    function automatic t_dir_row mk_chk(input logic [PIX_W-1:0] pix, input logic [7:0] red,
                                        input logic [7:0] green, input logic [7:0] blue,
                                        input logic rd, input logic fd);
        t_dir_row r;
        r = mk_pix(pix);
        r.typed = 1'b1;
        r.want = {red, green, blue, rd, fd};
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return 24'hFFFFFF;
            1: return 24'h000000;
            2: return {{8{1'($urandom)}}, {8{1'($urandom)}}, {8{1'($urandom)}}};
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic int extreme_dim();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 1;
            2: return 256;
            3: return 257;
            default: return 511;
        endcase
    endfunction

    task automatic push_pixel(input logic [PIX_W-1:0] pix, input int gap, input bit typed,
                              input t_tile_avg want);
        bit        hit;
        t_tile_avg res;
        if (gap > 0) begin
            @(negedge i_clk);
            pix_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        pix_if.valid = 1'b1;
        pix_if.pixel_color = pix;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        box_avg_step(pix, hit, res);
        if (typed) begin
            tile_q.push_back(want);
        end else if (hit) begin
            tile_q.push_back(res);
        end
    endtask

    // Bring the block to idle: no item offered, all tiles out, pipeline drained
    task automatic settle();
        @(negedge i_clk);
        pix_if.valid = 1'b0;
        cfg_we = 1'b0;
        while (tile_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = data;
        box_cfg_write(idx, data);
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // Result side: random stalls, calm stretches, one long hold-off on request
    initial begin : tile_sink
        int        stall;
        int        calm_left;
        bit        hold_taken;
        t_tile_avg got;
        t_tile_avg want;
        calm_left = 0;
        hold_taken = 1'b0;
        avg_if.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                stall = HOLD_CYC;
            end else if (calm_left > 0) begin
                calm_left--;
                stall = 0;
            end else if ($urandom_range(0, 15) == 0) begin
                calm_left = $urandom_range(8, 40);
                stall = 0;
            end else begin
                stall = $urandom_range(0, 7);
            end
            if (stall > 0) begin
                @(negedge i_clk);
                avg_if.ready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            avg_if.ready = 1'b1;
            @(posedge i_clk);
            while (!avg_if.valid) @(posedge i_clk);
            got = {avg_if.avg_red, avg_if.avg_green, avg_if.avg_blue,
                   avg_if.row_done, avg_if.frame_done};
            if (tile_q.size() == 0) begin
                err_cnt++;
                $display("%0t: tile result with none expected: got %h/%h/%h row %b frame %b",
                         $time, got.red, got.green, got.blue, got.row_done, got.frame_done);
            end else begin
                want = tile_q.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.row_done !== want.row_done ||
                    got.frame_done !== want.frame_done) begin
                    err_cnt++;
                    $display("%0t: tile mismatch: expected %h/%h/%h %b%b, got %h/%h/%h %b%b",
                             $time, want.red, want.green, want.blue, want.row_done,
                             want.frame_done, got.red, got.green, got.blue, got.row_done,
                             got.frame_done);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake and no register write
    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || (pix_if.valid && pix_if.ready) ||
            (avg_if.valid && avg_if.ready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stim
        t_dir_row              dir_tab [$];
        int                    rnd_pix;
        int                    wv, hv, bv, shape, mode, frame, n, mult;
        bit                    no_gap;
        logic [CFG_DATA_W-1:0] bdata;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        pix_if.valid = 1'b0;
        pix_if.pixel_color = '0;
        wid_cfg = DIM_REG_W'(RST_FRAME_WIDTH);
        hgt_cfg = DIM_REG_W'(RST_FRAME_HEIGHT);
        bs_cfg = BS_REG_W'(RST_BLOCK_SIZE);
        restart_pos();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset geometry: two pixels into the first row of a 160 wide frame, nothing comes out
        dir_tab.push_back(mk_pix(24'h123456));
        dir_tab.push_back(mk_pix(24'hABCDEF));
        // Zero registers read as one: every pixel is its own tile and frame
        dir_tab.push_back(mk_cfg(CFG_FRAME_WIDTH, 9'd0));
        dir_tab.push_back(mk_cfg(CFG_FRAME_HEIGHT, 9'd0));
        dir_tab.push_back(mk_cfg(CFG_BLOCK_SIZE, 9'd0));
        dir_tab.push_back(mk_chk(24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
        dir_tab.push_back(mk_chk(24'h000000, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));
        dir_tab.push_back(mk_chk(24'h123456, 8'h12, 8'h34, 8'h56, 1'b1, 1'b1));
        // Tile saturated to 16 but cut to 2x1 by the frame edge
        dir_tab.push_back(mk_cfg(CFG_FRAME_WIDTH, 9'd2));
        dir_tab.push_back(mk_cfg(CFG_FRAME_HEIGHT, 9'd1));
        dir_tab.push_back(mk_cfg(CFG_BLOCK_SIZE, 9'h1FF));
        dir_tab.push_back(mk_pix(24'hFF00FF));
        dir_tab.push_back(mk_chk(24'h01FF00, 8'h80, 8'h7F, 8'h7F, 1'b1, 1'b1));
        // Write to the spare index mid-frame must not restart the frame
        dir_tab.push_back(mk_pix(24'h800002));
        dir_tab.push_back(mk_cfg(CFG_SPARE_IDX, 9'h1FF));
        dir_tab.push_back(mk_chk(24'h800001, 8'h80, 8'h00, 8'h01, 1'b1, 1'b1));
        // Oversized width and height saturate
        dir_tab.push_back(mk_cfg(CFG_FRAME_WIDTH, 9'h1FF));
        dir_tab.push_back(mk_cfg(CFG_FRAME_HEIGHT, 9'd300));
        dir_tab.push_back(mk_cfg(CFG_BLOCK_SIZE, 9'd1));
        dir_tab.push_back(mk_chk(24'h00FF00, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0));
        dir_tab.push_back(mk_pix(24'hA5A5A5));
        dir_tab.push_back(mk_pix(24'h5A5A5A));
        // One column frame, bottom tile cut to a single pixel
        dir_tab.push_back(mk_cfg(CFG_FRAME_WIDTH, 9'd1));
        dir_tab.push_back(mk_cfg(CFG_FRAME_HEIGHT, 9'd3));
        dir_tab.push_back(mk_cfg(CFG_BLOCK_SIZE, 9'd2));
        dir_tab.push_back(mk_pix(24'h204060));
        dir_tab.push_back(mk_pix(24'h102030));
        dir_tab.push_back(mk_chk(24'h0F0F0F, 8'h0F, 8'h0F, 8'h0F, 1'b1, 1'b1));
        // Widest frame with largest tile: no tile closes
        dir_tab.push_back(mk_cfg(CFG_FRAME_WIDTH, 9'd256));
        dir_tab.push_back(mk_cfg(CFG_FRAME_HEIGHT, 9'd1));
        dir_tab.push_back(mk_cfg(CFG_BLOCK_SIZE, 9'd17));
        dir_tab.push_back(mk_pix(24'hFFFFFF));
        dir_tab.push_back(mk_pix(24'h000000));

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                settle();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end else begin
                push_pixel(dir_tab[i].pix, $urandom_range(0, 7), dir_tab[i].typed,
                           dir_tab[i].want);
            end
        end

        // Random phases: mostly whole frames of small geometry, some cut short
        rnd_pix = 0;
        while (rnd_pix < RAND_ITEMS) begin
            settle();
            shape = $urandom_range(0, 15);
            if (shape == 0) begin
                wv = extreme_dim();
                hv = $urandom_range(0, 3);
            end else if (shape == 1) begin
                wv = $urandom_range(0, 3);
                hv = extreme_dim();
            end else if (shape == 2) begin
                wv = $urandom_range(100, 511);
                hv = $urandom_range(1, 3);
            end else begin
                wv = $urandom_range(1, 24);
                hv = $urandom_range(1, 16);
            end
            bv = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
            bdata = CFG_DATA_W'(bv);
            if ($urandom_range(0, 7) == 0) bdata[CFG_DATA_W-1:BS_REG_W] = 4'($urandom);
            write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(wv));
            write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(hv));
            write_reg(CFG_BLOCK_SIZE, bdata);
            if ($urandom_range(0, 9) == 0) write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));

            frame = fit_range(wv, MAX_W) * fit_range(hv, MAX_H);
            mode = $urandom_range(0, 5);
            if (mode == 0) begin
                n = $urandom_range(1, frame);
            end else begin
                mult = (frame > 200) ? 1 : $urandom_range(1, 3);
                n = frame * mult;
                if (mode == 1) n += $urandom_range(1, frame);
            end
            no_gap = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < n && rnd_pix < RAND_ITEMS; i++) begin
                push_pixel(rand_pixel(), no_gap ? 0 : $urandom_range(0, 7), 1'b0, '0);
                rnd_pix++;
                if (rnd_pix == RAND_ITEMS / 2) hold_req = 1'b1;
            end
        end

        @(negedge i_clk);
        pix_if.valid = 1'b0;
        while (tile_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* rgb_block_average_downscale.f */
sv/rbad_pkg.sv
sv/rbad_pix_if.sv
sv/rbad_avg_if.sv
sv/rbad_band_mem.sv
sv/rbad_divider.sv
sv/rgb_block_average_downscale.sv
tb/sv/rgb_block_average_downscale_tb.sv
